>>> rtl/ovlog_pkg.sv
package ovlog_pkg;

    localparam int ENTRIES     = 64;
    localparam int EXTRA_BYTES = 8;
    localparam int SLOT_W      = $clog2(ENTRIES);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int REQ_W       = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] MAX_TYPE_RESET = 8'd16;

    localparam logic [1:0] KIND_LOG      = 2'd0;
    localparam logic [1:0] KIND_COUNT    = 2'd1;
    localparam logic [1:0] KIND_RETRIEVE = 2'd2;
    localparam logic [1:0] KIND_STATUS   = 2'd3;

    typedef struct packed {
        logic [31:0] serial;
        logic [7:0]  etype;
        logic [31:0] result;
        logic [63:0] stamp;
        logic [31:0] subject;
        logic [31:0] object;
        logic [3:0]  xlen;
        logic [63:0] extra;
    } rec_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic             log_ok;
        logic             req_bad;
        logic [REQ_W-1:0] req;
        rec_t             rec;
    } cmd_t;

    typedef struct packed {
        logic        done;
        logic        status;
        logic        last;
        logic [31:0] reply_value;
        logic [31:0] write_position;
    } reply_t;

endpackage

>>> rtl/ovlog_front.sv
module ovlog_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_data,
    input  logic [1:0]             kind,
    input  logic [7:0]             event_type,
    input  logic signed [31:0]     result_code,
    input  logic signed [31:0]     subject_id,
    input  logic signed [31:0]     object_id,
    input  logic [63:0]            time_stamp,
    input  logic [3:0]             extra_length,
    input  logic [63:0]            extra_data,
    input  logic [6:0]             request_count,
    output ovlog_pkg::cmd_t        cmd
);

    logic [7:0]  max_type_reg;
    logic [63:0] extra_masked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_type_reg <= ovlog_pkg::MAX_TYPE_RESET;
        end
        else if (cfg_we)
        begin
            max_type_reg <= cfg_data;
        end
    end

    // zero the bytes beyond the given length
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            extra_masked[b*8 +: 8] = (4'(b) < extra_length) ? extra_data[b*8 +: 8] : 8'd0;
        end
    end

    always_comb
    begin
        cmd.kind         = kind;
        cmd.log_ok       = (event_type != 8'd0) && (event_type <= max_type_reg)
                           && (extra_length <= 4'(ovlog_pkg::EXTRA_BYTES));
        cmd.req_bad      = (request_count == 7'd0)
                           || (request_count > 7'(ovlog_pkg::ENTRIES));
        cmd.req          = request_count;
        cmd.rec.serial   = '0;
        cmd.rec.etype    = event_type;
        cmd.rec.result   = result_code;
        cmd.rec.stamp    = time_stamp;
        cmd.rec.subject  = subject_id;
        cmd.rec.object   = object_id;
        cmd.rec.xlen     = extra_length;
        cmd.rec.extra    = extra_masked;
    end

endmodule

>>> rtl/ovlog_queue.sv
module ovlog_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ovlog_pkg::cmd_t din,
    input  logic            pop,
    output ovlog_pkg::cmd_t dout,
    output logic            empty,
    output logic            full
);

    ovlog_pkg::cmd_t                    slot_reg [ovlog_pkg::QUEUE_DEPTH];
    logic [ovlog_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [ovlog_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [ovlog_pkg::QCNT_W-1:0]       fill_reg;
    logic                               do_push;
    logic                               do_pop;

    function automatic logic [ovlog_pkg::QPTR_W-1:0] ptr_inc(
        input logic [ovlog_pkg::QPTR_W-1:0] p);
        if (p == ovlog_pkg::QPTR_W'(ovlog_pkg::QUEUE_DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == ovlog_pkg::QCNT_W'(ovlog_pkg::QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> rtl/ovlog_back.sv
module ovlog_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  ovlog_pkg::cmd_t   head,
    output logic              pop,
    output ovlog_pkg::reply_t rply,
    output ovlog_pkg::rec_t   rec_out
);

    typedef enum logic {ST_IDLE, ST_READ} state_t;

    localparam int SW = ovlog_pkg::SLOT_W;
    localparam int CW = ovlog_pkg::CNT_W;
    localparam int RW = ovlog_pkg::REQ_W;

    state_t             state_reg;
    logic [31:0]        write_count_reg;
    logic [SW-1:0]      wr_slot_reg;
    logic [SW-1:0]      cur_slot_reg;
    logic [RW-1:0]      rem_reg;
    logic [RW-1:0]      total_reg;
    logic               done_reg;
    logic               status_reg;
    logic               last_reg;
    logic               rec_en_reg;
    logic [31:0]        reply_reg;
    logic [31:0]        wpos_reg;
    ovlog_pkg::rec_t    rd_reg;
    ovlog_pkg::rec_t    mem [ovlog_pkg::ENTRIES];

    logic [31:0]        serial_next;
    logic [SW-1:0]      wr_slot_next;
    logic [RW-1:0]      count;
    logic [CW-1:0]      count_c;
    logic [CW-1:0]      start_wide;
    logic [SW-1:0]      start_slot;
    logic               ret_go;
    logic               mem_we;
    logic               mem_re;
    logic [SW-1:0]      rd_addr;
    ovlog_pkg::rec_t    wr_rec;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        if (s == SW'(ovlog_pkg::ENTRIES - 1))
            return '0;
        return s + 1'b1;
    endfunction

    assign pop         = (state_reg == ST_IDLE) && !q_empty;
    assign serial_next = write_count_reg + 32'd1;
    // the slot sequence restarts when the write count wraps
    assign wr_slot_next = (write_count_reg == '1) ? '0 : slot_inc(wr_slot_reg);

    always_comb
    begin
        if (write_count_reg < 32'(head.req))
            count = write_count_reg[RW-1:0];
        else
            count = head.req;
        count_c = CW'(count);
        if ({1'b0, wr_slot_reg} >= count_c)
            start_wide = {1'b0, wr_slot_reg} - count_c;
        else
            start_wide = {1'b0, wr_slot_reg} + CW'(ovlog_pkg::ENTRIES) - count_c;
        start_slot = start_wide[SW-1:0];
    end

    assign ret_go  = pop && (head.kind == ovlog_pkg::KIND_RETRIEVE) && !head.req_bad
                     && (count != '0);
    assign mem_we  = pop && (head.kind == ovlog_pkg::KIND_LOG) && head.log_ok;
    assign mem_re  = ret_go || (state_reg == ST_READ);
    assign rd_addr = (state_reg == ST_READ) ? cur_slot_reg : start_slot;

    always_comb
    begin
        wr_rec        = head.rec;
        wr_rec.serial = serial_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_slot_reg] <= wr_rec;
        end
        if (mem_re)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            write_count_reg <= '0;
            wr_slot_reg     <= '0;
            cur_slot_reg    <= '0;
            rem_reg         <= '0;
            total_reg       <= '0;
            done_reg        <= 1'b0;
            status_reg      <= 1'b0;
            last_reg        <= 1'b0;
            rec_en_reg      <= 1'b0;
            reply_reg       <= '0;
            wpos_reg        <= '0;
        end
        else
        begin
            done_reg   <= 1'b0;
            rec_en_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= 1'b0;
                        last_reg   <= 1'b1;
                        wpos_reg   <= '0;
                        reply_reg  <= '0;
                        case (head.kind)
                            ovlog_pkg::KIND_LOG:
                            begin
                                if (head.log_ok)
                                begin
                                    reply_reg       <= serial_next;
                                    write_count_reg <= serial_next;
                                    wr_slot_reg     <= wr_slot_next;
                                end
                            end
                            ovlog_pkg::KIND_COUNT:
                            begin
                                if (write_count_reg >= 32'(ovlog_pkg::ENTRIES))
                                    reply_reg <= 32'(ovlog_pkg::ENTRIES);
                                else
                                    reply_reg <= write_count_reg;
                            end
                            ovlog_pkg::KIND_STATUS:
                            begin
                                reply_reg <= 32'(ovlog_pkg::ENTRIES);
                                wpos_reg  <= write_count_reg;
                            end
                            ovlog_pkg::KIND_RETRIEVE:
                            begin
                                if (head.req_bad)
                                begin
                                    status_reg <= 1'b1;
                                end
                                else if (ret_go)
                                begin
                                    rec_en_reg   <= 1'b1;
                                    reply_reg    <= 32'(count);
                                    last_reg     <= (count == RW'(1));
                                    total_reg    <= count;
                                    rem_reg      <= count - 1'b1;
                                    cur_slot_reg <= slot_inc(start_slot);
                                    if (count != RW'(1))
                                    begin
                                        state_reg <= ST_READ;
                                    end
                                end
                            end
                            default:
                            begin
                                status_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    // deliver one record a cycle, oldest first
                    done_reg     <= 1'b1;
                    status_reg   <= 1'b0;
                    rec_en_reg   <= 1'b1;
                    wpos_reg     <= '0;
                    reply_reg    <= 32'(total_reg);
                    last_reg     <= (rem_reg == RW'(1));
                    rem_reg      <= rem_reg - 1'b1;
                    cur_slot_reg <= slot_inc(cur_slot_reg);
                    if (rem_reg == RW'(1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rply.done           = done_reg;
    assign rply.status         = status_reg;
    assign rply.last           = last_reg;
    assign rply.reply_value    = reply_reg;
    assign rply.write_position = wpos_reg;
    assign rec_out             = rec_en_reg ? rd_reg : '0;

endmodule

>>> rtl/overwriting_event_log_buffer_core.sv
// Channel  | Direction | Handshake               | Payload
// request  | in        | start, busy             | kind .. request_count
// config   | in        | cfg_valid, cfg_ready    | cfg_data (largest event type)
// result   | out       | done (one-cycle strobe) | status .. last
//
// In the executing stage, a retrieve of k records delivers them one after another,
// as the record memory has a single read port; a log, count or status request gives
// a single result. The first result of each request is driven in the cycle after
// the back pops the request from the queue. A two-entry queue sits between the
// classifying front and the executing back; busy is high while it is full. Reset
// clears the write count and the queue, not the record memory. The receiver cannot
// stall: results are driven for one cycle.
module overwriting_event_log_buffer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [7:0]         event_type,
    input  logic signed [31:0] result_code,
    input  logic signed [31:0] subject_id,
    input  logic signed [31:0] object_id,
    input  logic [63:0]        time_stamp,
    input  logic [3:0]         extra_length,
    input  logic [63:0]        extra_data,
    input  logic [6:0]         request_count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    output logic               done,
    output logic               status,
    output logic [31:0]        reply_value,
    output logic [31:0]        write_position,
    output logic [31:0]        out_serial,
    output logic [7:0]         out_type,
    output logic signed [31:0] out_result,
    output logic [63:0]        out_time,
    output logic signed [31:0] out_subject,
    output logic signed [31:0] out_object,
    output logic [3:0]         out_extra_length,
    output logic [63:0]        out_extra,
    output logic               last
);

    ovlog_pkg::cmd_t   front_cmd;
    ovlog_pkg::cmd_t   head_cmd;
    ovlog_pkg::reply_t rply;
    ovlog_pkg::rec_t   rec;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    logic              accept;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;
    assign accept    = start && !q_full;

    ovlog_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .event_type    (event_type),
        .result_code   (result_code),
        .subject_id    (subject_id),
        .object_id     (object_id),
        .time_stamp    (time_stamp),
        .extra_length  (extra_length),
        .extra_data    (extra_data),
        .request_count (request_count),
        .cmd           (front_cmd)
    );

    ovlog_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .din   (front_cmd),
        .pop   (pop),
        .dout  (head_cmd),
        .empty (q_empty),
        .full  (q_full)
    );

    ovlog_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (head_cmd),
        .pop     (pop),
        .rply    (rply),
        .rec_out (rec)
    );

    assign done             = rply.done;
    assign status           = rply.status;
    assign last             = rply.last;
    assign reply_value      = rply.reply_value;
    assign write_position   = rply.write_position;
    assign out_serial       = rec.serial;
    assign out_type         = rec.etype;
    assign out_result       = rec.result;
    assign out_time         = rec.stamp;
    assign out_subject      = rec.subject;
    assign out_object       = rec.object;
    assign out_extra_length = rec.xlen;
    assign out_extra        = rec.extra;

`ifndef SYNTHESIS
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |=> (done && reply_value == $past(reply_value)))
        else $error("retrieve burst broken");

    a_bad_request: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (last && reply_value == 32'd0))
        else $error("invalid request reply malformed");

    a_extra_len: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_extra_length <= 4'(ovlog_pkg::EXTRA_BYTES)))
        else $error("delivered extra length out of range");
`endif

endmodule

>>> dv/event_log_checker.sv
`timescale 1ns / 100ps

module event_log_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  kind,
    input  logic [7:0]  event_type,
    input  logic [31:0] result_code,
    input  logic [31:0] subject_id,
    input  logic [31:0] object_id,
    input  logic [63:0] time_stamp,
    input  logic [3:0]  extra_length,
    input  logic [63:0] extra_data,
    input  logic [6:0]  request_count,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        done,
    input  logic        status,
    input  logic [31:0] reply_value,
    input  logic [31:0] write_position,
    input  logic [31:0] out_serial,
    input  logic [7:0]  out_type,
    input  logic [31:0] out_result,
    input  logic [63:0] out_time,
    input  logic [31:0] out_subject,
    input  logic [31:0] out_object,
    input  logic [3:0]  out_extra_length,
    input  logic [63:0] out_extra,
    input  logic        last,
    output int unsigned outstanding,
    output int unsigned fail_count
);

    typedef struct packed {
        logic            status;
        logic [31:0]     reply;
        logic [31:0]     wpos;
        ovlog_pkg::rec_t rec;
        logic            last;
    } reply_beat_t;

    reply_beat_t     pending_replies[$];
    ovlog_pkg::rec_t log_ring[ovlog_pkg::ENTRIES];
    logic [31:0]     write_total;
    logic [7:0]      type_limit;

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track_log
        reply_beat_t     beat;
        ovlog_pkg::rec_t entry;
        logic [31:0]     deliver;
        logic [31:0]     first_slot;
        logic [63:0]     keep_mask;
        int unsigned     k;
        if (!rst_n)
        begin
            pending_replies.delete();
            write_total = '0;
            type_limit  = ovlog_pkg::MAX_TYPE_RESET;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                type_limit = cfg_data;

            if (done)
            begin
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none actual reply %h last %b",
                             $time, reply_value, last);
                    fail_count++;
                end
                else
                begin
                    beat = pending_replies.pop_front();
                    compare_field("status", beat.status, status);
                    compare_field("reply_value", beat.reply, reply_value);
                    compare_field("write_position", beat.wpos, write_position);
                    compare_field("out_serial", beat.rec.serial, out_serial);
                    compare_field("out_type", beat.rec.etype, out_type);
                    compare_field("out_result", beat.rec.result, out_result);
                    compare_field("out_time", beat.rec.stamp, out_time);
                    compare_field("out_subject", beat.rec.subject, out_subject);
                    compare_field("out_object", beat.rec.object, out_object);
                    compare_field("out_extra_length", beat.rec.xlen, out_extra_length);
                    compare_field("out_extra", beat.rec.extra, out_extra);
                    compare_field("last", beat.last, last);
                end
            end

            if (start && !busy)
            begin
                beat      = '0;
                beat.last = 1'b1;
                case (kind)
                    ovlog_pkg::KIND_LOG:
                    begin
                        if (event_type != 8'd0 && event_type <= type_limit &&
                            extra_length <= ovlog_pkg::EXTRA_BYTES)
                        begin
                            keep_mask = (extra_length >= 4'd8) ? '1 :
                                        ((64'd1 << (8 * extra_length)) - 64'd1);
                            entry.serial  = write_total + 32'd1;
                            entry.etype   = event_type;
                            entry.result  = result_code;
                            entry.stamp   = time_stamp;
                            entry.subject = subject_id;
                            entry.object  = object_id;
                            entry.xlen    = extra_length;
                            entry.extra   = extra_data & keep_mask;
                            log_ring[write_total % ovlog_pkg::ENTRIES] = entry;
                            write_total = write_total + 32'd1;
                            beat.reply  = write_total;
                        end
                        pending_replies.push_back(beat);
                    end
                    ovlog_pkg::KIND_COUNT:
                    begin
                        beat.reply = (write_total >= ovlog_pkg::ENTRIES) ?
                                     ovlog_pkg::ENTRIES : write_total;
                        pending_replies.push_back(beat);
                    end
                    ovlog_pkg::KIND_STATUS:
                    begin
                        beat.reply = ovlog_pkg::ENTRIES;
                        beat.wpos  = write_total;
                        pending_replies.push_back(beat);
                    end
                    default:
                    begin
                        if (request_count == '0 || request_count > ovlog_pkg::ENTRIES)
                        begin
                            beat.status = 1'b1;
                            pending_replies.push_back(beat);
                        end
                        else
                        begin
                            deliver = request_count;
                            if (deliver > write_total)
                                deliver = write_total;
                            if (deliver == 0)
                                pending_replies.push_back(beat);
                            else
                            begin
                                // oldest of the newest records first
                                first_slot = (write_total - deliver) % ovlog_pkg::ENTRIES;
                                for (k = 0; k < deliver; k++)
                                begin
                                    beat.reply = deliver;
                                    beat.rec   = log_ring[(first_slot + k) %
                                                          ovlog_pkg::ENTRIES];
                                    beat.last  = (k + 1 == deliver);
                                    pending_replies.push_back(beat);
                                end
                            end
                        end
                    end
                endcase
            end
            outstanding <= pending_replies.size();
        end
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int STALL_LIMIT = 600;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  etype;
        logic [31:0] result;
        logic [31:0] subject;
        logic [31:0] object;
        logic [63:0] stamp;
        logic [3:0]  xlen;
        logic [63:0] extra;
        logic [6:0]  req;
    } log_request_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         kind;
    logic [7:0]         event_type;
    logic signed [31:0] result_code;
    logic signed [31:0] subject_id;
    logic signed [31:0] object_id;
    logic [63:0]        time_stamp;
    logic [3:0]         extra_length;
    logic [63:0]        extra_data;
    logic [6:0]         request_count;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_data;
    logic               done;
    logic               status;
    logic [31:0]        reply_value;
    logic [31:0]        write_position;
    logic [31:0]        out_serial;
    logic [7:0]         out_type;
    logic signed [31:0] out_result;
    logic [63:0]        out_time;
    logic signed [31:0] out_subject;
    logic signed [31:0] out_object;
    logic [3:0]         out_extra_length;
    logic [63:0]        out_extra;
    logic               last;

    int unsigned outstanding;
    int unsigned fail_count;
    int unsigned quiet_cycles;
    int unsigned burst_left;
    logic [7:0]  type_cap;

    overwriting_event_log_buffer_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .kind             (kind),
        .event_type       (event_type),
        .result_code      (result_code),
        .subject_id       (subject_id),
        .object_id        (object_id),
        .time_stamp       (time_stamp),
        .extra_length     (extra_length),
        .extra_data       (extra_data),
        .request_count    (request_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .done             (done),
        .status           (status),
        .reply_value      (reply_value),
        .write_position   (write_position),
        .out_serial       (out_serial),
        .out_type         (out_type),
        .out_result       (out_result),
        .out_time         (out_time),
        .out_subject      (out_subject),
        .out_object       (out_object),
        .out_extra_length (out_extra_length),
        .out_extra        (out_extra),
        .last             (last)
    );

    event_log_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .kind             (kind),
        .event_type       (event_type),
        .result_code      (result_code),
        .subject_id       (subject_id),
        .object_id        (object_id),
        .time_stamp       (time_stamp),
        .extra_length     (extra_length),
        .extra_data       (extra_data),
        .request_count    (request_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .done             (done),
        .status           (status),
        .reply_value      (reply_value),
        .write_position   (write_position),
        .out_serial       (out_serial),
        .out_type         (out_type),
        .out_result       (out_result),
        .out_time         (out_time),
        .out_subject      (out_subject),
        .out_object       (out_object),
        .out_extra_length (out_extra_length),
        .out_extra        (out_extra),
        .last             (last),
        .outstanding      (outstanding),
        .fail_count       (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // end the run when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic log_request_t random_fields(input logic [1:0] k);
        log_request_t r;
        r.kind    = k;
        r.etype   = 8'($urandom);
        r.result  = $urandom;
        r.subject = $urandom;
        r.object  = $urandom;
        r.stamp   = {$urandom, $urandom};
        r.xlen    = 4'($urandom);
        r.extra   = {$urandom, $urandom};
        r.req     = 7'($urandom);
        return r;
    endfunction

    // hold the request until taken, then close the burst with a gap now and then
    task automatic issue(input log_request_t r);
        int unsigned gap;
        start         <= 1'b1;
        kind          <= r.kind;
        event_type    <= r.etype;
        result_code   <= r.result;
        subject_id    <= r.subject;
        object_id     <= r.object;
        time_stamp    <= r.stamp;
        extra_length  <= r.xlen;
        extra_data    <= r.extra;
        request_count <= r.req;
        do
            @(posedge clk);
        while (busy);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_type_cap(input logic [7:0] cap);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        type_cap = cap;
    endtask

    initial
    begin : stimulus
        log_request_t r;
        int unsigned  pick;
        int unsigned  phase;
        int unsigned  n;
        logic [7:0]   phase_cap;

        rst_n         = 1'b0;
        start         = 1'b0;
        kind          = ovlog_pkg::KIND_LOG;
        event_type    = '0;
        result_code   = '0;
        subject_id    = '0;
        object_id     = '0;
        time_stamp    = '0;
        extra_length  = '0;
        extra_data    = '0;
        request_count = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        burst_left    = 4;
        type_cap      = ovlog_pkg::MAX_TYPE_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty history, queries and bad requests
        r = random_fields(ovlog_pkg::KIND_RETRIEVE); r.req = 7'd5;   issue(r);
        r = random_fields(ovlog_pkg::KIND_COUNT);                    issue(r);
        r = random_fields(ovlog_pkg::KIND_STATUS);                   issue(r);
        r = random_fields(ovlog_pkg::KIND_RETRIEVE); r.req = 7'd0;   issue(r);
        r = random_fields(ovlog_pkg::KIND_RETRIEVE); r.req = 7'd65;  issue(r);
        r = random_fields(ovlog_pkg::KIND_RETRIEVE); r.req = 7'd127; issue(r);

        // rejected logs: zero type, type above the limit, extra too long
        r = random_fields(ovlog_pkg::KIND_LOG); r.etype = 8'd0;   r.xlen = 4'd2; issue(r);
        r = random_fields(ovlog_pkg::KIND_LOG); r.etype = 8'd17;  r.xlen = 4'd2; issue(r);
        r = random_fields(ovlog_pkg::KIND_LOG); r.etype = 8'd255; r.xlen = 4'd2; issue(r);
        r = random_fields(ovlog_pkg::KIND_LOG); r.etype = 8'd16;  r.xlen = 4'd9; issue(r);
        r = random_fields(ovlog_pkg::KIND_LOG); r.etype = 8'd1;   r.xlen = 4'd15; issue(r);

        r = '0;
        r.kind  = ovlog_pkg::KIND_LOG;
        r.etype = 8'd1;
        issue(r);
        r.etype   = 8'd16;
        r.result  = 32'h8000_0000;
        r.subject = 32'h7fff_ffff;
        r.object  = 32'hffff_ffff;
        r.stamp   = '1;
        r.xlen    = 4'd8;
        r.extra   = '1;
        issue(r);
        r.etype   = 8'd8;
        r.result  = 32'h7fff_ffff;
        r.subject = 32'h8000_0000;
        r.object  = '0;
        r.stamp   = '0;
        r.xlen    = 4'd3;
        issue(r);
        for (n = 1; n <= 7; n++)
        begin
            r = random_fields(ovlog_pkg::KIND_LOG);
            r.etype = 8'($urandom_range(1, 16));
            r.xlen  = 4'(n);
            issue(r);
        end

        // ask for more than has been logged, then the newest alone
        r = random_fields(ovlog_pkg::KIND_RETRIEVE); r.req = 7'd64; issue(r);
        r = random_fields(ovlog_pkg::KIND_RETRIEVE); r.req = 7'd1;  issue(r);
        r = random_fields(ovlog_pkg::KIND_COUNT);                   issue(r);
        r = random_fields(ovlog_pkg::KIND_STATUS);                  issue(r);
        drain();

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       phase_cap = 8'd255;
                1:       phase_cap = 8'd0;
                2:       phase_cap = 8'd1;
                3:       phase_cap = 8'($urandom_range(2, 254));
                default: phase_cap = ovlog_pkg::MAX_TYPE_RESET;
            endcase
            write_type_cap(phase_cap);
            for (n = 0; n < 51; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    r = random_fields(ovlog_pkg::KIND_LOG);
                    if ($urandom_range(0, 6) != 0)
                    begin
                        if (type_cap != 8'd0)
                            r.etype = 8'($urandom_range(1, type_cap));
                        r.xlen = 4'($urandom_range(0, ovlog_pkg::EXTRA_BYTES));
                    end
                    else
                    begin
                        case ($urandom_range(0, 2))
                            0: r.etype = 8'd0;
                            1: r.etype = (type_cap == 8'd255) ? 8'd0 :
                                         8'($urandom_range(type_cap + 1, 255));
                            default: r.xlen = 4'($urandom_range(ovlog_pkg::EXTRA_BYTES + 1,
                                                                15));
                        endcase
                    end
                end
                else if (pick < 75)
                begin
                    r = random_fields(ovlog_pkg::KIND_RETRIEVE);
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        r.req = 7'($urandom_range(1, 16));
                    else if (pick < 9)
                        r.req = 7'($urandom_range(17, ovlog_pkg::ENTRIES));
                    else
                        r.req = ($urandom_range(0, 1) == 0) ? 7'd0 :
                                7'($urandom_range(ovlog_pkg::ENTRIES + 1, 127));
                end
                else if (pick < 87)
                    r = random_fields(ovlog_pkg::KIND_COUNT);
                else
                    r = random_fields(ovlog_pkg::KIND_STATUS);
                issue(r);
            end
            drain();
        end

        // let any stray result show itself
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
